// ===== design/two_source_audio_mixer_soft_clip_assert.svh =====
// ----------------------------------------------------------------------------
// two_source_audio_mixer_soft_clip assertion macros
// Shared concurrent assertion forms, clocked on i_clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef TWO_SOURCE_AUDIO_MIXER_SOFT_CLIP_ASSERT_SVH
`define TWO_SOURCE_AUDIO_MIXER_SOFT_CLIP_ASSERT_SVH

// condition that holds at every edge
`define TSAM_ASSERT(label, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) else $error(msg);

// antecedent implies consequent in the same cycle
`define TSAM_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== design/tsam_pkg.sv =====
// ----------------------------------------------------------------------------
// tsam_pkg
// Types, register codes and fixed-point constants of the two-source mixer.
// ----------------------------------------------------------------------------
`default_nettype none

package tsam_pkg;

    typedef struct packed {
        logic signed [15:0] system_sample;
        logic signed [15:0] mic_sample;
        logic               system_present;
        logic               mic_present;
        logic               last_in;
    } t_in;

    typedef struct packed {
        logic signed [15:0] mixed_sample;
        logic               last_out;
    } t_out;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] system_volume;
        logic [7:0] mic_volume;
    } t_cfg;

    typedef enum logic {
        KIND_SINGLE,
        KIND_MIX
    } t_kind;

    // scaled sample (single) or scaled sum (mix), units of 1/100
    typedef struct packed {
        t_kind              kind;
        logic signed [24:0] value;
        logic               last;
    } t_entry;

    typedef struct packed {
        logic full;
        logic empty;
    } t_fifo_stat;

    // register indexes
    localparam logic [1:0] CFG_MODE    = 2'd0;
    localparam logic [1:0] CFG_SYS_VOL = 2'd1;
    localparam logic [1:0] CFG_MIC_VOL = 2'd2;

    // mode codes, all other codes mix
    localparam logic [1:0] MODE_SYS = 2'd0;
    localparam logic [1:0] MODE_MIC = 2'd1;

    localparam logic [1:0] RST_MODE = 2'd2;
    localparam logic [7:0] RST_VOL  = 8'd100;
    localparam logic [7:0] GAIN_CAP = 8'd160;

    localparam int QUEUE_DEPTH = 2;

    // reciprocals: ceil(2^30/100), ceil(2^29/25), ceil(2^20/3), ceil(2^22/3)
    localparam logic [24:0] RECIP_100  = 25'd10737419;
    localparam logic [24:0] RECIP_25   = 25'd21474837;
    localparam logic [18:0] RECIP_3_18 = 19'd349526;
    localparam logic [20:0] RECIP_3_20 = 21'd1398102;

    // floor(r * 2^13 / 25) for remainders of the divide by 25
    localparam logic [12:0] FRAC25 [25] = '{
        13'd0,    13'd327,  13'd655,  13'd983,  13'd1310,
        13'd1638, 13'd1966, 13'd2293, 13'd2621, 13'd2949,
        13'd3276, 13'd3604, 13'd3932, 13'd4259, 13'd4587,
        13'd4915, 13'd5242, 13'd5570, 13'd5898, 13'd6225,
        13'd6553, 13'd6881, 13'd7208, 13'd7536, 13'd7864
    };

    localparam logic signed [15:0] SAT_MAX = 16'sh7FFF;
    localparam logic signed [15:0] SAT_MIN = 16'sh8000;

endpackage

`default_nettype wire

// ===== design/tsam_fifo.sv =====
// ----------------------------------------------------------------------------
// tsam_fifo
// Short register queue between the classifying front and the arithmetic back.
// ----------------------------------------------------------------------------
`default_nettype none

module tsam_fifo #(
    parameter int DEPTH = tsam_pkg::QUEUE_DEPTH
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire tsam_pkg::t_entry i_entry,
    input  wire logic             i_pop,
    output tsam_pkg::t_entry      o_head,
    output tsam_pkg::t_fifo_stat  o_stat
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    tsam_pkg::t_entry r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr;
    logic [PW-1:0]    r_rd_ptr;
    logic [CW-1:0]    r_count;
    logic [CW-1:0]    n_count;
    logic             full;
    logic             empty;
    logic             do_push;
    logic             do_pop;

    assign full    = (r_count == CW'(DEPTH));
    assign empty   = (r_count == '0);
    assign do_push = i_push && !full;
    assign do_pop  = i_pop && !empty;

    always_comb begin
        n_count = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    assign o_head = r_mem[r_rd_ptr];
    assign o_stat = {full, empty};

endmodule

`default_nettype wire

// ===== design/tsam_front.sv =====
// ----------------------------------------------------------------------------
// tsam_front
// Takes sample pairs, applies capped gains, sorts each into single or mix or drops it.
// ----------------------------------------------------------------------------
`default_nettype none

module tsam_front (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    input  wire tsam_pkg::t_in        i_item,
    input  wire tsam_pkg::t_cfg       i_cfg,
    input  wire tsam_pkg::t_fifo_stat i_fifo_stat,
    output logic                      o_busy,
    output logic                      o_push,
    output tsam_pkg::t_entry          o_entry
);

    logic               r_valid;
    tsam_pkg::t_entry   r_entry;
    logic [7:0]         gain_s;
    logic [7:0]         gain_m;
    logic signed [24:0] prod_s;
    logic signed [24:0] prod_m;
    logic signed [24:0] sum;
    logic               keep;
    tsam_pkg::t_entry   n_entry;
    logic               accept;

    assign gain_s = (i_cfg.system_volume > tsam_pkg::GAIN_CAP) ? tsam_pkg::GAIN_CAP
                                                               : i_cfg.system_volume;
    assign gain_m = (i_cfg.mic_volume > tsam_pkg::GAIN_CAP) ? tsam_pkg::GAIN_CAP
                                                            : i_cfg.mic_volume;

    assign prod_s = i_item.system_sample * $signed({1'b0, gain_s});
    assign prod_m = i_item.mic_sample * $signed({1'b0, gain_m});
    assign sum    = prod_s + prod_m;

    always_comb begin
        keep          = 1'b0;
        n_entry.kind  = tsam_pkg::KIND_SINGLE;
        n_entry.value = prod_s;
        n_entry.last  = i_item.last_in;
        unique case (i_cfg.mode)
            tsam_pkg::MODE_SYS: begin
                keep = i_item.system_present;
            end
            tsam_pkg::MODE_MIC: begin
                keep          = i_item.mic_present;
                n_entry.value = prod_m;
            end
            default: begin
                keep = i_item.system_present || i_item.mic_present;
                if (i_item.system_present && i_item.mic_present) begin
                    n_entry.kind  = tsam_pkg::KIND_MIX;
                    n_entry.value = sum;
                end else if (i_item.mic_present) begin
                    n_entry.value = prod_m;
                end
            end
        endcase
    end

    assign o_push = r_valid && !i_fifo_stat.full;
    assign o_busy = r_valid && i_fifo_stat.full;
    assign accept = i_start && !o_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= keep;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_entry <= n_entry;
        end
    end

    assign o_entry = r_entry;

endmodule

`default_nettype wire

// ===== design/tsam_back.sv =====
// ----------------------------------------------------------------------------
// tsam_back
// Fixed-point pipeline: divide by 100 or 25, cubic soft clip, saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module tsam_back (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    input  wire tsam_pkg::t_entry i_entry,
    output logic                  o_strobe,
    output tsam_pkg::t_out        o_result
);

    // stage 0: magnitude times reciprocal
    logic        r_s0_valid, r_s0_mix, r_s0_neg, r_s0_last;
    logic [23:0] r_s0_n;
    logic [19:0] r_s0_q;
    // stage 1: q30 t magnitude, single result
    logic        r_s1_valid, r_s1_mix, r_s1_neg, r_s1_last;
    logic [31:0] r_s1_a;
    logic [15:0] r_s1_res;
    // stage 2: square
    logic        r_s2_valid, r_s2_mix, r_s2_neg, r_s2_last;
    logic [31:0] r_s2_a;
    logic [29:0] r_s2_x;
    logic [15:0] r_s2_res;
    // stage 3: cube
    logic        r_s3_valid, r_s3_mix, r_s3_neg, r_s3_last;
    logic [31:0] r_s3_a;
    logic [35:0] r_s3_cube;
    logic [15:0] r_s3_res;
    // stage 4: upper part of divide by 3
    logic        r_s4_valid, r_s4_mix, r_s4_neg, r_s4_last;
    logic [31:0] r_s4_a;
    logic [16:0] r_s4_qh;
    logic [1:0]  r_s4_rh;
    logic [17:0] r_s4_l;
    logic [15:0] r_s4_res;
    // stage 5: lower part of divide by 3
    logic        r_s5_valid, r_s5_mix, r_s5_neg, r_s5_last;
    logic [31:0] r_s5_a;
    logic [34:0] r_s5_quot;
    logic [15:0] r_s5_res;
    // stage 6: signed result in q30
    logic               r_s6_valid, r_s6_mix, r_s6_last;
    logic signed [36:0] r_s6_y;
    logic [15:0]        r_s6_res;
    // output
    logic           r_strobe;
    tsam_pkg::t_out r_result;

    logic        in_mix;
    logic        in_neg;
    logic [24:0] abs_v;
    logic [24:0] recip;
    logic [48:0] prod0;
    logic [19:0] q0;

    logic [24:0] q25;
    logic [24:0] rem25;
    logic [4:0]  rem;
    logic [31:0] a1;
    logic [15:0] res1;

    logic [63:0] sq;
    logic [61:0] p3;
    logic [36:0] p4;
    logic [16:0] qh;
    logic [17:0] rh18;
    logic [19:0] m5;
    logic [40:0] p5;
    logic [18:0] qm;
    logic signed [36:0] y6;

    logic signed [36:0] adj;
    logic signed [21:0] tq;
    logic signed [15:0] mix_res;

    assign in_mix = (i_entry.kind == tsam_pkg::KIND_MIX);
    assign in_neg = i_entry.value[24];
    assign abs_v  = in_neg ? 25'(-i_entry.value) : 25'(i_entry.value);
    assign recip  = in_mix ? tsam_pkg::RECIP_25 : tsam_pkg::RECIP_100;
    assign prod0  = 49'(abs_v[23:0]) * 49'(recip);
    assign q0     = in_mix ? prod0[48:29] : {1'b0, prod0[48:30]};

    assign q25   = 25'({r_s0_q, 4'b0}) + 25'({r_s0_q, 3'b0}) + 25'(r_s0_q);
    assign rem25 = 25'(r_s0_n) - q25;
    assign rem   = rem25[4:0];
    assign a1    = {r_s0_q[18:0], 13'b0} + 32'(tsam_pkg::FRAC25[rem]);

    always_comb begin
        if (!r_s0_neg) begin
            res1 = (r_s0_q > 20'd32767) ? tsam_pkg::SAT_MAX : r_s0_q[15:0];
        end else begin
            res1 = (r_s0_q > 20'd32768) ? tsam_pkg::SAT_MIN : 16'(-r_s0_q);
        end
    end

    assign sq   = 64'(r_s1_a) * 64'(r_s1_a);
    assign p3   = 62'(r_s2_x) * 62'(r_s2_a);
    assign p4   = 37'(r_s3_cube[35:18]) * 37'(tsam_pkg::RECIP_3_18);
    assign qh   = p4[36:20];
    assign rh18 = r_s3_cube[35:18] - (18'({qh, 1'b0}) + 18'(qh));
    assign m5   = {r_s4_rh, r_s4_l};
    assign p5   = 41'(m5) * 41'(tsam_pkg::RECIP_3_20);
    assign qm   = p5[40:22];
    assign y6   = r_s5_neg ? $signed(37'(r_s5_quot) - 37'(r_s5_a))
                           : $signed(37'(r_s5_a) - 37'(r_s5_quot));

    // truncate toward zero, then saturate
    assign adj = r_s6_y + (r_s6_y[36] ? 37'sd32767 : 37'sd0);
    assign tq  = 22'(adj >>> 15);

    always_comb begin
        if (tq > 22'sd32767) begin
            mix_res = tsam_pkg::SAT_MAX;
        end else if (tq < -22'sd32768) begin
            mix_res = tsam_pkg::SAT_MIN;
        end else begin
            mix_res = tq[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            r_s4_valid <= 1'b0;
            r_s5_valid <= 1'b0;
            r_s6_valid <= 1'b0;
            r_strobe   <= 1'b0;
        end else begin
            r_s0_valid <= i_valid;
            r_s1_valid <= r_s0_valid;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
            r_s4_valid <= r_s3_valid;
            r_s5_valid <= r_s4_valid;
            r_s6_valid <= r_s5_valid;
            r_strobe   <= r_s6_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s0_mix  <= in_mix;
        r_s0_neg  <= in_neg;
        r_s0_last <= i_entry.last;
        r_s0_n    <= abs_v[23:0];
        r_s0_q    <= q0;

        r_s1_mix  <= r_s0_mix;
        r_s1_neg  <= r_s0_neg;
        r_s1_last <= r_s0_last;
        r_s1_a    <= a1;
        r_s1_res  <= res1;

        r_s2_mix  <= r_s1_mix;
        r_s2_neg  <= r_s1_neg;
        r_s2_last <= r_s1_last;
        r_s2_a    <= r_s1_a;
        r_s2_x    <= sq[63:34];
        r_s2_res  <= r_s1_res;

        r_s3_mix  <= r_s2_mix;
        r_s3_neg  <= r_s2_neg;
        r_s3_last <= r_s2_last;
        r_s3_a    <= r_s2_a;
        r_s3_cube <= p3[61:26];
        r_s3_res  <= r_s2_res;

        r_s4_mix  <= r_s3_mix;
        r_s4_neg  <= r_s3_neg;
        r_s4_last <= r_s3_last;
        r_s4_a    <= r_s3_a;
        r_s4_qh   <= qh;
        r_s4_rh   <= rh18[1:0];
        r_s4_l    <= r_s3_cube[17:0];
        r_s4_res  <= r_s3_res;

        r_s5_mix  <= r_s4_mix;
        r_s5_neg  <= r_s4_neg;
        r_s5_last <= r_s4_last;
        r_s5_a    <= r_s4_a;
        r_s5_quot <= {r_s4_qh, qm[17:0]};
        r_s5_res  <= r_s4_res;

        r_s6_mix  <= r_s5_mix;
        r_s6_last <= r_s5_last;
        r_s6_y    <= y6;
        r_s6_res  <= r_s5_res;

        r_result.mixed_sample <= r_s6_mix ? mix_res : r_s6_res;
        r_result.last_out     <= r_s6_last;
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

endmodule

`default_nettype wire

// ===== design/two_source_audio_mixer_soft_clip.sv =====
// ----------------------------------------------------------------------------
// two_source_audio_mixer_soft_clip
// Two-source audio mixer with percent gains and cubic soft clip.
//
// channel   direction  handshake             payload
// item      in         start high, busy low  i_item    (t_in)
// result    out        o_strobe, one cycle   o_result  (t_out)
// config    in         i_cfg_we              i_cfg_idx, i_cfg_data
//
// one item per clock while busy is low; the back end multiply chain is pipelined
// an item runs front register, queue, back stages 0-6, output; no-result items drop
// reset is synchronous and restores mode mix and both gains to 100 percent
// busy rises only if the queue is full while the front holds an item
// the result side cannot stall, the back end drains the queue every cycle
// ----------------------------------------------------------------------------
`default_nettype none

`include "two_source_audio_mixer_soft_clip_assert.svh"

module two_source_audio_mixer_soft_clip #(
    parameter int QUEUE_DEPTH = tsam_pkg::QUEUE_DEPTH
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          start,
    output logic               busy,
    input  wire tsam_pkg::t_in i_item,
    output logic               o_strobe,
    output tsam_pkg::t_out     o_result,
    input  wire logic          i_cfg_we,
    input  wire logic [1:0]    i_cfg_idx,
    input  wire logic [7:0]    i_cfg_data
);

    tsam_pkg::t_cfg       r_cfg;
    tsam_pkg::t_fifo_stat fifo_stat;
    tsam_pkg::t_entry     push_entry;
    tsam_pkg::t_entry     head;
    logic                 push;
    logic                 pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode          <= tsam_pkg::RST_MODE;
            r_cfg.system_volume <= tsam_pkg::RST_VOL;
            r_cfg.mic_volume    <= tsam_pkg::RST_VOL;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                tsam_pkg::CFG_MODE:    r_cfg.mode          <= i_cfg_data[1:0];
                tsam_pkg::CFG_SYS_VOL: r_cfg.system_volume <= i_cfg_data;
                tsam_pkg::CFG_MIC_VOL: r_cfg.mic_volume    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    tsam_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_item      (i_item),
        .i_cfg       (r_cfg),
        .i_fifo_stat (fifo_stat),
        .o_busy      (busy),
        .o_push      (push),
        .o_entry     (push_entry)
    );

    tsam_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .i_pop   (pop),
        .o_head  (head),
        .o_stat  (fifo_stat)
    );

    assign pop = !fifo_stat.empty;

    tsam_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (pop),
        .i_entry  (head),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    `TSAM_ASSERT_IMPL(a_no_overflow, push, !fifo_stat.full, "push into full queue")
    `TSAM_ASSERT_IMPL(a_busy_full, busy, fifo_stat.full, "busy without full queue")
    `TSAM_ASSERT_IMPL(a_strobe_src, o_strobe, $past(!fifo_stat.empty, 8), "result without queued item")

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the two-source audio mixer with cubic soft clip.
// A directed table covers reset values, full-scale samples, absent sources,
// gain caps and every mode. Random phases follow, each with its own register
// setting and in even phases random item gaps. Every result is checked field
// by field against a table row or a model of gain, mix and soft-clip math.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

    localparam logic [1:0] CFG_SPARE    = 2'd3;
    localparam logic [1:0] MODE_MIX     = 2'd2;
    localparam logic [1:0] MODE_MIX_ALT = 2'd3;
    localparam int         IDLE_LIMIT   = 1000;
    localparam int         SETTLE       = 12;
    localparam int         N_DIRECTED   = 25;
    localparam int         N_PHASES     = 10;
    localparam int         PHASE_ITEMS  = 40;

    typedef struct {
        tsam_pkg::t_cfg  cfg;
        tsam_pkg::t_in   item;
        bit              typed;
        bit              some;
        tsam_pkg::t_out  res;
    } t_row;

    logic            i_clk      = 1'b0;
    logic            i_rst_n    = 1'b0;
    logic            start      = 1'b0;
    logic            busy;
    tsam_pkg::t_in   item_r     = '0;
    logic            o_strobe;
    tsam_pkg::t_out  o_result;
    logic            i_cfg_we   = 1'b0;
    logic [1:0]      i_cfg_idx  = '0;
    logic [7:0]      i_cfg_data = '0;

    // typed expectation travelling with the item being offered
    bit              typed_r    = 1'b0;
    bit              typed_some = 1'b0;
    tsam_pkg::t_out  typed_res  = '0;

    tsam_pkg::t_cfg  shadow_cfg;
    tsam_pkg::t_out  expected_samples[$];
    int              n_errors   = 0;
    int              idle_cycles = 0;
    t_row            dir_rows[N_DIRECTED];

    two_source_audio_mixer_soft_clip dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_item     (item_r),
        .o_strobe   (o_strobe),
        .o_result   (o_result),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    function automatic bit predict_sample(input tsam_pkg::t_in it, input tsam_pkg::t_cfg c,
                                          output tsam_pkg::t_out res);
        longint          ss;
        longint          ms;
        longint          gs;
        longint          gm;
        longint          v;
        longint          r;
        longint          s;
        longint unsigned mag;
        longint unsigned a;
        longint unsigned sq;
        longint unsigned cube;
        bit              use_sys;
        bit              use_mic;
        bit              neg;
        ss = $signed(it.system_sample);
        ms = $signed(it.mic_sample);
        gs = (c.system_volume > tsam_pkg::GAIN_CAP) ? longint'(tsam_pkg::GAIN_CAP)
                                                    : longint'(c.system_volume);
        gm = (c.mic_volume > tsam_pkg::GAIN_CAP) ? longint'(tsam_pkg::GAIN_CAP)
                                                 : longint'(c.mic_volume);
        use_sys = 1'b0;
        use_mic = 1'b0;
        res = '0;
        if (c.mode == tsam_pkg::MODE_SYS) begin
            use_sys = it.system_present;
        end else if (c.mode == tsam_pkg::MODE_MIC) begin
            use_mic = it.mic_present;
        end else begin
            use_sys = it.system_present;
            use_mic = it.mic_present;
        end
        if (use_sys && use_mic) begin
            s = ss * gs + ms * gm;
            neg = s < 0;
            mag = neg ? -s : s;
            a = (mag << 13) / 25;
            sq = (a * a) >> 30;
            cube = ((sq >> 4) * a) >> 26;
            r = $signed(a) - $signed(cube / 3);
            if (neg) begin
                r = -r;
            end
            v = r / 32768;
        end else if (use_sys) begin
            v = (ss * gs) / 100;
        end else if (use_mic) begin
            v = (ms * gm) / 100;
        end else begin
            return 1'b0;
        end
        if (v > 32767) begin
            v = 32767;
        end else if (v < -32768) begin
            v = -32768;
        end
        res.mixed_sample = v[15:0];
        res.last_out = it.last_in;
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t ns: %s", $realtime, what);
        n_errors++;
    endtask

    // model update and result check
    always @(posedge i_clk) begin
        tsam_pkg::t_out exp_res;
        tsam_pkg::t_out got;
        if (!i_rst_n) begin
            shadow_cfg.mode          <= tsam_pkg::RST_MODE;
            shadow_cfg.system_volume <= tsam_pkg::RST_VOL;
            shadow_cfg.mic_volume    <= tsam_pkg::RST_VOL;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    tsam_pkg::CFG_MODE:    shadow_cfg.mode          <= i_cfg_data[1:0];
                    tsam_pkg::CFG_SYS_VOL: shadow_cfg.system_volume <= i_cfg_data;
                    tsam_pkg::CFG_MIC_VOL: shadow_cfg.mic_volume    <= i_cfg_data;
                    default: ;
                endcase
            end
            if (start && !busy) begin
                if (typed_r) begin
                    if (typed_some) begin
                        expected_samples.push_back(typed_res);
                    end
                end else if (predict_sample(item_r, shadow_cfg, exp_res)) begin
                    expected_samples.push_back(exp_res);
                end
            end
            if (o_strobe) begin
                got = o_result;
                if (expected_samples.size() == 0) begin
                    report_mismatch($sformatf("unexpected result %0d last %0b",
                                              $signed(got.mixed_sample), got.last_out));
                end else begin
                    exp_res = expected_samples.pop_front();
                    if (got.mixed_sample !== exp_res.mixed_sample) begin
                        report_mismatch($sformatf("mixed_sample %0d, expected %0d",
                                                  $signed(got.mixed_sample),
                                                  $signed(exp_res.mixed_sample)));
                    end
                    if (got.last_out !== exp_res.last_out) begin
                        report_mismatch($sformatf("last_out %0b, expected %0b",
                                                  got.last_out, exp_res.last_out));
                    end
                end
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_strobe || i_cfg_we) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    function automatic t_row mk_row(input logic [1:0] m, input logic [7:0] sv,
                                    input logic [7:0] mv, input int ss, input int ms,
                                    input bit sp, input bit mp, input bit lst,
                                    input bit typed, input bit some, input int val);
        t_row r;
        r.cfg.mode               = m;
        r.cfg.system_volume      = sv;
        r.cfg.mic_volume         = mv;
        r.item.system_sample     = 16'(ss);
        r.item.mic_sample        = 16'(ms);
        r.item.system_present    = sp;
        r.item.mic_present       = mp;
        r.item.last_in           = lst;
        r.typed                  = typed;
        r.some                   = some;
        r.res.mixed_sample       = 16'(val);
        r.res.last_out           = lst;
        return r;
    endfunction

    function automatic logic signed [15:0] rand_sample();
        case ($urandom_range(0, 7))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            2:       return 16'($signed($urandom_range(0, 400)) - 200);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [7:0] rand_volume();
        case ($urandom_range(0, 5))
            0:       return 8'd0;
            1:       return tsam_pkg::GAIN_CAP;
            2:       return 8'd255;
            3:       return tsam_pkg::RST_VOL;
            default: return 8'($urandom);
        endcase
    endfunction

    // offer one item, return at the edge of its transfer
    task automatic send_item(input tsam_pkg::t_in it, input bit typed, input bit some,
                             input tsam_pkg::t_out res, input int gap);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start      <= 1'b1;
        item_r     <= it;
        typed_r    <= typed;
        typed_some <= some;
        typed_res  <= res;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    // wait for every pending result, then let dropped items clear the pipe
    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (expected_samples.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic program_regs(input tsam_pkg::t_cfg c, input bit poke_spare);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= tsam_pkg::CFG_MODE;
        i_cfg_data <= {6'($urandom), c.mode};
        @(posedge i_clk);
        i_cfg_idx  <= tsam_pkg::CFG_SYS_VOL;
        i_cfg_data <= c.system_volume;
        @(posedge i_clk);
        i_cfg_idx  <= tsam_pkg::CFG_MIC_VOL;
        i_cfg_data <= c.mic_volume;
        @(posedge i_clk);
        if (poke_spare) begin
            i_cfg_idx  <= CFG_SPARE;
            i_cfg_data <= 8'($urandom);
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        tsam_pkg::t_cfg cur_cfg;
        tsam_pkg::t_in  it;
        tsam_pkg::t_out none_res;
        bit             spare_done;
        int             gap;
        none_res   = '0;
        spare_done = 1'b0;
        cur_cfg.mode          = tsam_pkg::RST_MODE;
        cur_cfg.system_volume = tsam_pkg::RST_VOL;
        cur_cfg.mic_volume    = tsam_pkg::RST_VOL;

        dir_rows[0]  = mk_row(tsam_pkg::RST_MODE, 100, 100, 0, 0, 1, 1, 0, 1, 1, 0);
        dir_rows[1]  = mk_row(tsam_pkg::RST_MODE, 100, 100, 1, 1, 1, 1, 0, 1, 1, 2);
        dir_rows[2]  = mk_row(tsam_pkg::RST_MODE, 100, 100, -1, -1, 1, 1, 1, 1, 1, -2);
        dir_rows[3]  = mk_row(tsam_pkg::RST_MODE, 100, 100, 32767, 32767, 1, 1, 0, 0, 0, 0);
        dir_rows[4]  = mk_row(tsam_pkg::RST_MODE, 100, 100, -32768, -32768, 1, 1, 1, 0, 0, 0);
        dir_rows[5]  = mk_row(tsam_pkg::RST_MODE, 100, 100, 32767, -32768, 1, 1, 0, 1, 1, -1);
        dir_rows[6]  = mk_row(tsam_pkg::RST_MODE, 100, 100, 32767, 0, 1, 0, 0, 1, 1, 32767);
        dir_rows[7]  = mk_row(tsam_pkg::RST_MODE, 100, 100, 0, -32768, 0, 1, 1, 1, 1, -32768);
        dir_rows[8]  = mk_row(tsam_pkg::RST_MODE, 100, 100, 123, 456, 0, 0, 1, 1, 0, 0);
        dir_rows[9]  = mk_row(tsam_pkg::MODE_SYS, 160, 0, 32767, 5, 1, 0, 0, 1, 1, 32767);
        dir_rows[10] = mk_row(tsam_pkg::MODE_SYS, 160, 0, -32768, -32768, 1, 1, 0, 1, 1,
                              -32768);
        dir_rows[11] = mk_row(tsam_pkg::MODE_SYS, 160, 0, -1, 32767, 1, 1, 1, 1, 1, -1);
        dir_rows[12] = mk_row(tsam_pkg::MODE_SYS, 160, 0, 100, 100, 0, 1, 0, 1, 0, 0);
        dir_rows[13] = mk_row(tsam_pkg::MODE_MIC, 0, 255, 7, -32768, 1, 1, 0, 1, 1, -32768);
        dir_rows[14] = mk_row(tsam_pkg::MODE_MIC, 0, 255, 0, 1, 0, 1, 1, 1, 1, 1);
        dir_rows[15] = mk_row(tsam_pkg::MODE_MIC, 0, 255, 32767, 200, 1, 0, 0, 1, 0, 0);
        dir_rows[16] = mk_row(MODE_MIX_ALT, 0, 0, 32767, 32767, 1, 1, 0, 1, 1, 0);
        dir_rows[17] = mk_row(MODE_MIX_ALT, 0, 0, -32768, 0, 1, 0, 1, 1, 1, 0);
        dir_rows[18] = mk_row(MODE_MIX_ALT, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0);
        dir_rows[19] = mk_row(MODE_MIX, 160, 160, 32767, 32767, 1, 1, 1, 0, 0, 0);
        dir_rows[20] = mk_row(MODE_MIX, 160, 160, -32768, -32768, 1, 1, 0, 0, 0, 0);
        dir_rows[21] = mk_row(MODE_MIX, 160, 160, 20000, 20000, 1, 1, 0, 0, 0, 0);
        dir_rows[22] = mk_row(MODE_MIX, 161, 200, 12345, -2000, 1, 1, 1, 0, 0, 0);
        dir_rows[23] = mk_row(MODE_MIX, 161, 200, 32767, -5, 1, 0, 0, 1, 1, 32767);
        dir_rows[24] = mk_row(MODE_MIX, 99, 101, -12345, 23456, 1, 1, 1, 0, 0, 0);

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[k]) begin
            if (dir_rows[k].cfg != cur_cfg) begin
                drain();
                program_regs(dir_rows[k].cfg, !spare_done);
                spare_done = 1'b1;
                cur_cfg = dir_rows[k].cfg;
            end
            send_item(dir_rows[k].item, dir_rows[k].typed, dir_rows[k].some,
                      dir_rows[k].res, $urandom_range(0, 4));
        end

        for (int p = 0; p < N_PHASES; p++) begin
            drain();
            cur_cfg.mode          = (p < 4) ? 2'(p) : 2'($urandom_range(0, 3));
            cur_cfg.system_volume = rand_volume();
            cur_cfg.mic_volume    = rand_volume();
            program_regs(cur_cfg, p == N_PHASES - 1);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (p == 2 && n == PHASE_ITEMS / 2) begin
                    drain();
                end
                it.system_sample = rand_sample();
                it.mic_sample    = rand_sample();
                if ($urandom_range(0, 9) < 7) begin
                    it.system_present = 1'b1;
                    it.mic_present    = 1'b1;
                end else begin
                    it.system_present = 1'($urandom);
                    it.mic_present    = 1'($urandom);
                end
                it.last_in = ($urandom_range(0, 3) == 0);
                // odd phases run back to back
                gap = (p % 2 == 1) ? 0 : $urandom_range(0, 4);
                send_item(it, 1'b0, 1'b0, none_res, gap);
            end
        end

        drain();
        repeat (SETTLE) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
